/* design/fmsa_pkg.sv */
// Shared widths, register codes, sideband type and helpers for the mass-shell adjuster.
package fmsa_pkg;

  localparam int WORD_W = 32;
  localparam int MASS_W = 31;
  localparam int SQ_W   = 2 * WORD_W;
  localparam int ROOT_W = WORD_W;
  localparam int LANES  = 3;

  // register index, taken from paddr bit 2
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_MASS = 1'b1;

  localparam logic MODE_ENERGY   = 1'b0;
  localparam logic MODE_MOMENTUM = 1'b1;

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic                          valid;
    logic                          mode;
    logic                          space;
    logic [MASS_W-1:0]             mass;
    logic [LANES-1:0][WORD_W-1:0]  p;
    logic [WORD_W-1:0]             e;
    logic [ROOT_W-1:0]             root;
    logic [LANES-1:0]              ovf;
  } sb_t;

  function automatic logic [WORD_W-1:0] mag(logic [WORD_W-1:0] x);
    return x[WORD_W-1] ? (~x + WORD_W'(1)) : x;
  endfunction

endpackage

/* design/fmsa_particle_if.sv */
// Input channel: one four-momentum per beat.
interface fmsa_particle_if;
  logic                        valid;
  logic                        ready;
  logic [fmsa_pkg::WORD_W-1:0] px_in;
  logic [fmsa_pkg::WORD_W-1:0] py_in;
  logic [fmsa_pkg::WORD_W-1:0] pz_in;
  logic [fmsa_pkg::WORD_W-1:0] energy_in;

  modport source(output valid, px_in, py_in, pz_in, energy_in, input ready);
  modport sink(input valid, px_in, py_in, pz_in, energy_in, output ready);
endinterface

/* design/fmsa_result_if.sv */
// Output channel: one adjusted four-momentum with flags per beat.
interface fmsa_result_if;
  logic                        valid;
  logic                        ready;
  logic [fmsa_pkg::WORD_W-1:0] px_out;
  logic [fmsa_pkg::WORD_W-1:0] py_out;
  logic [fmsa_pkg::WORD_W-1:0] pz_out;
  logic [fmsa_pkg::WORD_W-1:0] energy_out;
  logic                        space_like;
  logic                        saturated;

  modport source(output valid, px_out, py_out, pz_out, energy_out, space_like, saturated,
                 input ready);
  modport sink(input valid, px_out, py_out, pz_out, energy_out, space_like, saturated,
               output ready);
endinterface

/* design/fmsa_sqrt_cell.sv */
// One stage of the integer square root: settles one result bit.
module fmsa_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [fmsa_pkg::SQ_W-1:0] v_in,
  input  logic [fmsa_pkg::SQ_W-1:0] r_in,
  output logic [fmsa_pkg::SQ_W-1:0] v_out,
  output logic [fmsa_pkg::SQ_W-1:0] r_out
);
  localparam logic [fmsa_pkg::SQ_W-1:0] BIT = fmsa_pkg::SQ_W'(1) << (2 * K);

  logic [fmsa_pkg::SQ_W-1:0] trial;
  assign trial = r_in + BIT;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v_in >= trial) begin
        v_out <= v_in - trial;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        v_out <= v_in;
        r_out <= r_in >> 1;
      end
    end
  end
endmodule

/* design/fmsa_div_cell.sv */
// One stage of restoring division: settles quotient bit K.
module fmsa_div_cell #(
  parameter int unsigned K = 0
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [fmsa_pkg::SQ_W-1:0]   rem_in,
  input  logic [fmsa_pkg::WORD_W-1:0] q_in,
  input  logic [fmsa_pkg::WORD_W-1:0] d_in,
  output logic [fmsa_pkg::SQ_W-1:0]   rem_out,
  output logic [fmsa_pkg::WORD_W-1:0] q_out,
  output logic [fmsa_pkg::WORD_W-1:0] d_out
);
  logic [fmsa_pkg::SQ_W-1:0] dk;
  assign dk = fmsa_pkg::SQ_W'(d_in) << K;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_out <= d_in;
      if (rem_in >= dk) begin
        rem_out <= rem_in - dk;
        q_out   <= q_in | (fmsa_pkg::WORD_W'(1) << K);
      end else begin
        rem_out <= rem_in;
        q_out   <= q_in;
      end
    end
  end
endmodule

/* design/four_momentum_mass_shell_adjust_top.sv */
// Top level of the mass-shell adjuster: config registers, pipeline and output register.
//
// Puts one four-momentum (px, py, pz, E, signed Q16.16) per beat on the mass shell of
// target_mass. The particle channel takes a beat whenever valid and ready are high; the
// result channel gives one beat per particle, in order, with valid/ready.
// Configuration is an APB-style read/write port: adjust_mode at 0x0, target_mass at 0x4;
// they must be written only while the pipeline is empty; the block does not enforce this.
// Path from accepted beat to result valid: capture, squares and sums registers, a row of
// 32 square-root cells (one root bit each), scaling multiply and range check registers,
// a row of 32 divider cells per component (one quotient bit each) and the output register.
// One beat enters and one leaves every cycle unless the receiver stalls.
// A stalled receiver freezes the whole row of cells and the output register together;
// ready on the particle side drops only while a finished result waits and is not taken.
// Reset (synchronous, active high) empties the pipeline and clears both registers.
module four_momentum_mass_shell_adjust_top (
  input  logic                  clk,
  input  logic                  rst,
  fmsa_particle_if.sink         particle,
  fmsa_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int W  = fmsa_pkg::WORD_W;
  localparam int SQ = fmsa_pkg::SQ_W;
  localparam int L  = fmsa_pkg::LANES;

  // configuration registers
  logic                        mode;
  logic [fmsa_pkg::MASS_W-1:0] mass;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= fmsa_pkg::MODE_ENERGY;
      mass <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        fmsa_pkg::REG_MODE: mode <= pwdata[0];
        fmsa_pkg::REG_MASS: mass <= pwdata[fmsa_pkg::MASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fmsa_pkg::REG_MODE: prdata = {31'b0, mode};
      fmsa_pkg::REG_MASS: prdata = {1'b0, mass};
      default:            prdata = '0;
    endcase
  end

  // whole pipeline advances together
  logic adv;
  logic out_valid;
  assign adv            = !out_valid || result.ready;
  assign particle.ready = adv;

  // stage a: capture beat
  fmsa_pkg::sb_t sb_a, sb_b, sb_c, sb_d, sb_e;
  fmsa_pkg::sb_t sb_a_next, sb_c_next, sb_d_next, sb_e_next;

  always_comb begin
    sb_a_next       = '0;
    sb_a_next.valid = particle.valid;
    sb_a_next.mode  = mode;
    sb_a_next.mass  = mass;
    sb_a_next.p[0]  = particle.px_in;
    sb_a_next.p[1]  = particle.py_in;
    sb_a_next.p[2]  = particle.pz_in;
    sb_a_next.e     = particle.energy_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_a <= '0;
    end else if (adv) begin
      sb_a <= sb_a_next;
    end
  end

  // stage b: squares
  logic [L-1:0][SQ-1:0] sq_p;
  logic [SQ-1:0]        m2, e2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_b <= '0;
    end else if (adv) begin
      sb_b <= sb_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < L; i++) begin
        sq_p[i] <= SQ'(fmsa_pkg::mag(sb_a.p[i])) * SQ'(fmsa_pkg::mag(sb_a.p[i]));
      end
      m2 <= SQ'(sb_a.mass) * SQ'(sb_a.mass);
      e2 <= SQ'(fmsa_pkg::mag(sb_a.e)) * SQ'(fmsa_pkg::mag(sb_a.e));
    end
  end

  // stage c: radicands and space-like test
  logic [SQ-1:0] bsum;
  logic [SQ-1:0] rad_a, rad_b;
  assign bsum = sq_p[0] + sq_p[1] + sq_p[2];

  always_comb begin
    sb_c_next       = sb_b;
    sb_c_next.space = (sb_b.mode == fmsa_pkg::MODE_MOMENTUM) && !((e2 > m2) && (bsum != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_c <= '0;
    end else if (adv) begin
      sb_c <= sb_c_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // energy mode wraps the sum to 64 bits
      rad_a <= (sb_b.mode == fmsa_pkg::MODE_MOMENTUM) ? (e2 - m2) : (m2 + bsum);
      rad_b <= bsum;
    end
  end

  // square-root rows
  fmsa_pkg::sb_t     sq_sb [W+1];
  logic [SQ-1:0]     sa_v [W+1], sa_r [W+1], sb_v [W+1], sb_r [W+1];

  assign sq_sb[0] = sb_c;
  assign sa_v[0]  = rad_a;
  assign sa_r[0]  = '0;
  assign sb_v[0]  = rad_b;
  assign sb_r[0]  = '0;

  for (genvar j = 0; j < W; j++) begin : g_sqrt
    fmsa_sqrt_cell #(.K(W - 1 - j)) u_a (
      .clk(clk), .adv(adv), .v_in(sa_v[j]), .r_in(sa_r[j]),
      .v_out(sa_v[j+1]), .r_out(sa_r[j+1])
    );
    fmsa_sqrt_cell #(.K(W - 1 - j)) u_b (
      .clk(clk), .adv(adv), .v_in(sb_v[j]), .r_in(sb_r[j]),
      .v_out(sb_v[j+1]), .r_out(sb_r[j+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_sb[j+1] <= '0;
      end else if (adv) begin
        sq_sb[j+1] <= sq_sb[j];
      end
    end
  end

  // stage d: scale each component by the new magnitude
  logic [L-1:0][SQ-1:0] prod;
  logic [W-1:0]         md_d;

  always_comb begin
    sb_d_next      = sq_sb[W];
    sb_d_next.root = sa_r[W][W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_d <= '0;
    end else if (adv) begin
      sb_d <= sb_d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      md_d <= sb_r[W][W-1:0];
      for (int i = 0; i < L; i++) begin
        prod[i] <= SQ'(fmsa_pkg::mag(sq_sb[W].p[i])) * SQ'(sa_r[W][W-1:0]);
      end
    end
  end

  // stage e: flag quotients that need more than one word
  logic [L-1:0][SQ-1:0] rem_e;
  logic [W-1:0]         md_e;

  always_comb begin
    sb_e_next = sb_d;
    for (int i = 0; i < L; i++) begin
      sb_e_next.ovf[i] = prod[i][SQ-1:W] >= md_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_e <= '0;
    end else if (adv) begin
      sb_e <= sb_e_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_e <= prod;
      md_e  <= md_d;
    end
  end

  // divider rows, one per component
  fmsa_pkg::sb_t dv_sb [W+1];
  logic [SQ-1:0] dv_rem [L][W+1];
  logic [W-1:0]  dv_q   [L][W+1];
  logic [W-1:0]  dv_d   [L][W+1];

  assign dv_sb[0] = sb_e;

  for (genvar l = 0; l < L; l++) begin : g_lane
    assign dv_rem[l][0] = rem_e[l];
    assign dv_q[l][0]   = '0;
    assign dv_d[l][0]   = md_e;
    for (genvar j = 0; j < W; j++) begin : g_div
      fmsa_div_cell #(.K(W - 1 - j)) u_div (
        .clk(clk), .adv(adv),
        .rem_in(dv_rem[l][j]), .q_in(dv_q[l][j]), .d_in(dv_d[l][j]),
        .rem_out(dv_rem[l][j+1]), .q_out(dv_q[l][j+1]), .d_out(dv_d[l][j+1])
      );
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_dsb
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_sb[j+1] <= '0;
      end else if (adv) begin
        dv_sb[j+1] <= dv_sb[j];
      end
    end
  end

  // output formatting
  fmsa_pkg::sb_t     fin;
  logic [L-1:0][W-1:0] po;
  logic [W-1:0]      eo;
  logic              sat;
  logic [W-1:0]      q;

  assign fin = dv_sb[W];

  always_comb begin
    sat = 1'b0;
    po  = '0;
    q   = '0;
    for (int i = 0; i < L; i++) begin
      q = dv_q[i][W];
      if (fin.mode == fmsa_pkg::MODE_ENERGY) begin
        po[i] = fin.p[i];
      end else if (fin.space) begin
        po[i] = '0;
      end else if (fin.p[i][W-1]) begin
        if (fin.ovf[i] || (q > fmsa_pkg::SAT_MIN)) begin
          po[i] = fmsa_pkg::SAT_MIN;
          sat   = 1'b1;
        end else begin
          po[i] = ~q + W'(1);
        end
      end else begin
        if (fin.ovf[i] || q[W-1]) begin
          po[i] = fmsa_pkg::SAT_MAX;
          sat   = 1'b1;
        end else begin
          po[i] = q;
        end
      end
    end
    if (fin.mode == fmsa_pkg::MODE_ENERGY) begin
      if (fin.root[W-1]) begin
        eo  = fmsa_pkg::SAT_MAX;
        sat = 1'b1;
      end else begin
        eo = fin.root;
      end
    end else if (fin.space) begin
      eo = W'(fin.mass);
    end else begin
      eo = fin.e;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.px_out     <= po[0];
      result.py_out     <= po[1];
      result.pz_out     <= po[2];
      result.energy_out <= eo;
      result.space_like <= fin.space;
      result.saturated  <= sat;
    end
  end

  assign result.valid = out_valid;

  a_space_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.space_like |->
      result.px_out == '0 && result.py_out == '0 && result.pz_out == '0)
    else $error("space-like result with nonzero momentum");

  a_space_nosat: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.space_like |-> !result.saturated)
    else $error("space-like result flagged saturated");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid && !sb_a.valid && !fin.valid)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(fin) && $stable(sb_a))
    else $error("pipeline moved during stall");
endmodule
